// ----- hdl/scre_pkg.sv -----
`default_nettype none

package scre_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int LEVEL_BITS = 8;

  localparam int POS_W   = COORD_BITS + FRAC_BITS;
  localparam int LVL_W   = LEVEL_BITS + FRAC_BITS;
  localparam int K_W     = 17;
  localparam int GAIN_W  = 17;
  localparam int DLIM_W  = 22;
  localparam int CFG_W   = 22;
  localparam int CNT_W   = 8;
  localparam int Q_SHIFT = 16;

  localparam logic [K_W-1:0]     K_ONE          = K_W'(65536);
  localparam logic [GAIN_W-1:0]  GAIN_RESET     = GAIN_W'(65536);
  localparam logic [DLIM_W-1:0]  DLIM_RESET     = DLIM_W'(1280);

  typedef enum logic [0:0] {
    REG_GAIN       = 1'b0,
    REG_DIST_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    REQ_SEED   = 1'b0,
    REQ_UPDATE = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_DIST,
    S_MK,
    S_WK,
    S_MX,
    S_WX,
    S_WY,
    S_WL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [LEVEL_BITS-1:0] pix_level;
  } pixel_req_t;

  typedef struct packed {
    logic             accepted;
    logic [POS_W-1:0] cent_x;
    logic [POS_W-1:0] cent_y;
    logic [LVL_W-1:0] cent_level;
    logic [CNT_W-1:0] cent_count;
    logic [CNT_W-1:0] merged_total;
  } centroid_res_t;

endpackage

`default_nettype wire

// ----- hdl/star_centroid_running_estimator.sv -----
// A seed goes from acceptance straight to the result step; a rejected update first passes
// the difference and distance steps, and a merged update also the weight, x, y and level steps.
// Throughput: one item at a time; a new item is taken the cycle after the result is
// registered. A merged update is serialised through one shared 18x21 multiplier
// used for the weight, both coordinates and the brightness in turn.
// Reset (rst, synchronous) clears the centroid and counters, sets K and gain to 1.0.
`default_nettype none

module star_centroid_running_estimator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [scre_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire scre_pkg::pixel_req_t        in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output scre_pkg::centroid_res_t          out_data
);

  localparam int POS_W  = scre_pkg::POS_W;
  localparam int LVL_W  = scre_pkg::LVL_W;
  localparam int K_W    = scre_pkg::K_W;
  localparam int CNT_W  = scre_pkg::CNT_W;
  localparam int QS     = scre_pkg::Q_SHIFT;
  localparam int MA_W   = K_W + 1;
  localparam int MB_W   = POS_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SH_W   = PROD_W - QS;
  localparam int DIST_W = POS_W + 1;
  localparam int DLIM_W = scre_pkg::DLIM_W;
  localparam int CMP_W  = (DIST_W > DLIM_W) ? DIST_W : DLIM_W;

  localparam logic [K_W-1:0] K_ONE_EXT = scre_pkg::K_ONE;

  scre_pkg::state_t state, state_next;

  logic [scre_pkg::GAIN_W-1:0] gain;
  logic [DLIM_W-1:0]           distance_limit;

  logic [POS_W-1:0] pos_x, pos_y;
  logic [LVL_W-1:0] level_acc;
  logic [K_W-1:0]   weight_k;
  logic [CNT_W-1:0] seed_count, total_count;

  logic [POS_W-1:0] new_x, new_y;
  logic [LVL_W-1:0] new_level;
  logic             acc;

  logic signed [MB_W-1:0]   dx, dy, dl;
  logic signed [PROD_W-1:0] prod;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [SH_W-1:0]   prod_sh;

  logic [POS_W-1:0]  abs_dx, abs_dy;
  logic [DIST_W-1:0] manhattan;
  logic              hit;
  logic              k_sat;
  logic              in_take;
  logic              out_load;

  logic [POS_W-1:0] in_x, in_y;
  logic [LVL_W-1:0] in_level;

  assign in_x     = {in_data.pix_x, {scre_pkg::FRAC_BITS{1'b0}}};
  assign in_y     = {in_data.pix_y, {scre_pkg::FRAC_BITS{1'b0}}};
  assign in_level = {in_data.pix_level, {scre_pkg::FRAC_BITS{1'b0}}};

  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == scre_pkg::S_DONE) && (!out_valid || !out_stall);

  assign abs_dx    = dx[MB_W-1] ? POS_W'(-dx) : POS_W'(dx);
  assign abs_dy    = dy[MB_W-1] ? POS_W'(-dy) : POS_W'(dy);
  assign manhattan = DIST_W'(abs_dx) + DIST_W'(abs_dy);
  assign hit       = CMP_W'(manhattan) < CMP_W'(distance_limit);
  assign mul_a     = signed'({1'b0, weight_k});
  assign prod_sh   = prod[PROD_W-1:QS];
  assign k_sat     = prod_sh > SH_W'(K_ONE_EXT);

  always_comb begin
    state_next = state;
    case (state)
      scre_pkg::S_IDLE: begin
        if (in_take) begin
          if (in_data.req_type == scre_pkg::REQ_SEED) begin
            state_next = scre_pkg::S_DONE;
          end else begin
            state_next = scre_pkg::S_DIFF;
          end
        end
      end
      scre_pkg::S_DIFF: state_next = scre_pkg::S_DIST;
      scre_pkg::S_DIST: state_next = hit ? scre_pkg::S_MK : scre_pkg::S_DONE;
      scre_pkg::S_MK:   state_next = scre_pkg::S_WK;
      scre_pkg::S_WK:   state_next = scre_pkg::S_MX;
      scre_pkg::S_MX:   state_next = scre_pkg::S_WX;
      scre_pkg::S_WX:   state_next = scre_pkg::S_WY;
      scre_pkg::S_WY:   state_next = scre_pkg::S_WL;
      scre_pkg::S_WL:   state_next = scre_pkg::S_DONE;
      scre_pkg::S_DONE: begin
        if (out_load) begin
          state_next = scre_pkg::S_IDLE;
        end
      end
      default: state_next = scre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != scre_pkg::S_IDLE);
    case (state)
      scre_pkg::S_MK: mul_b = signed'(MB_W'(gain));
      scre_pkg::S_MX: mul_b = dx;
      scre_pkg::S_WX: mul_b = dy;
      scre_pkg::S_WY: mul_b = dl;
      default:        mul_b = dx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scre_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain           <= scre_pkg::GAIN_RESET;
      distance_limit <= scre_pkg::DLIM_RESET;
    end else if (cfg_we) begin
      case (scre_pkg::cfg_reg_t'(cfg_index))
        scre_pkg::REG_GAIN:       gain           <= cfg_data[scre_pkg::GAIN_W-1:0];
        scre_pkg::REG_DIST_LIMIT: distance_limit <= cfg_data[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      level_acc   <= '0;
      weight_k    <= scre_pkg::K_ONE;
      seed_count  <= '0;
      total_count <= '0;
      acc         <= 1'b0;
    end else begin
      case (state)
        scre_pkg::S_IDLE: begin
          if (in_take && in_data.req_type == scre_pkg::REQ_SEED) begin
            pos_x      <= in_x;
            pos_y      <= in_y;
            level_acc  <= in_level;
            seed_count <= CNT_W'(1);
            acc        <= 1'b1;
          end
        end
        scre_pkg::S_DIST: acc <= hit;
        scre_pkg::S_WK: weight_k <= k_sat ? scre_pkg::K_ONE : prod_sh[K_W-1:0];
        scre_pkg::S_WX: pos_x <= POS_W'(signed'(SH_W'(new_x)) + prod_sh);
        scre_pkg::S_WY: pos_y <= POS_W'(signed'(SH_W'(new_y)) + prod_sh);
        scre_pkg::S_WL: begin
          level_acc   <= LVL_W'(signed'(SH_W'(new_level)) + prod_sh);
          seed_count  <= seed_count + CNT_W'(1);
          total_count <= total_count + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      new_x     <= in_x;
      new_y     <= in_y;
      new_level <= in_level;
    end
    if (state == scre_pkg::S_DIFF) begin
      dx <= signed'({1'b0, pos_x}) - signed'({1'b0, new_x});
      dy <= signed'({1'b0, pos_y}) - signed'({1'b0, new_y});
      dl <= signed'(MB_W'(level_acc)) - signed'(MB_W'(new_level));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.accepted     <= acc;
      out_data.cent_x       <= pos_x;
      out_data.cent_y       <= pos_y;
      out_data.cent_level   <= level_acc;
      out_data.cent_count   <= seed_count;
      out_data.merged_total <= total_count;
    end
  end

  a_k_bounded: assert property (@(posedge clk) disable iff (rst)
    weight_k <= scre_pkg::K_ONE)
    else $error("weight K exceeds 1.0");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("input taken while an item is in progress");

  a_seed_count: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_data.req_type == scre_pkg::REQ_SEED) |=> (seed_count == CNT_W'(1)))
    else $error("seed did not set the pixel count to one");

  a_reject_keeps_k: assert property (@(posedge clk) disable iff (rst)
    (state == scre_pkg::S_DIST && !hit) |=> ($stable(weight_k) && $stable(pos_x)))
    else $error("rejected update changed the centroid state");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(state) == scre_pkg::S_DONE))
    else $error("result registered outside the final step");

endmodule

`default_nettype wire
